// File: design/dprh_pkg.sv
// ----------------------------------------------------------------------------
// dprh_pkg
// Shared types and constants for the dpcm residual histogram block.
// ----------------------------------------------------------------------------
`default_nettype none

package dprh_pkg;

  localparam int PIXEL_BITS     = 8;
  localparam int BIN_BITS       = 8;
  localparam int BINS           = 256;
  localparam int SIZE_BITS      = 9;
  localparam int BIN_COUNT_BITS = 17;
  localparam int CFG_INDEX_BITS = 4;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int COUNT_BITS_DEF = 17;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;

  // floor(s/3) for s below 1024 as (s * 683) >> 11
  localparam logic [19:0] DIV3_MUL   = 20'd683;
  localparam int          DIV3_SHIFT = 11;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_IMAGE_WIDTH  = 4'd0,
    CFG_IMAGE_HEIGHT = 4'd1
  } cfg_index_t;

endpackage

`default_nettype wire

// File: design/dprh_if.sv
// ----------------------------------------------------------------------------
// dprh_if
// Request, response and configuration channels of the residual histogram.
// ----------------------------------------------------------------------------
`default_nettype none

interface dprh_req_if import dprh_pkg::*; ();
  logic                  valid;
  logic                  ready;
  req_t                  req_type;
  logic [PIXEL_BITS-1:0] pixel;
  logic [BIN_BITS-1:0]   bin_index;

  modport source (output valid, req_type, pixel, bin_index, input ready);
  modport sink   (input valid, req_type, pixel, bin_index, output ready);
endinterface

interface dprh_rsp_if import dprh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PIXEL_BITS-1:0]     residual;
  logic [BIN_COUNT_BITS-1:0] bin_count;
  logic                      frame_last;

  modport source (output valid, residual, bin_count, frame_last, input ready);
  modport sink   (input valid, residual, bin_count, frame_last, output ready);
endinterface

interface dprh_cfg_if import dprh_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [SIZE_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: design/dpcm_residual_histogram.sv
// ----------------------------------------------------------------------------
// dpcm_residual_histogram: dpcm residual encoder with a 256-bin histogram
// requests pass stage 1 and stage 2 into the output queue; one transaction
// per cycle while req.ready is high, with histogram write forwarding
// reset: sizes 256, position and counts zero at once, no clearing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module dpcm_residual_histogram import dprh_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  dprh_req_if.sink   req,
  dprh_rsp_if.source rsp,
  dprh_cfg_if.sink   cfg
);

  localparam int CB = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RB = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int FB = $clog2(MAX_WIDTH + 1);
  localparam int WB = (CB + 1 > SIZE_BITS) ? CB + 1 : SIZE_BITS;
  localparam int HB = (RB + 1 > SIZE_BITS) ? RB + 1 : SIZE_BITS;
  localparam int XB = (COUNT_BITS > BIN_COUNT_BITS) ? COUNT_BITS : BIN_COUNT_BITS;
  localparam int QD = 4;
  localparam int QB = 2;

  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [PIXEL_BITS-1:0]     residual;
    logic [BIN_COUNT_BITS-1:0] bin_count;
    logic                      frame_last;
  } rsp_t;

  // configuration
  logic [SIZE_BITS-1:0] image_width;
  logic [SIZE_BITS-1:0] image_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data;
        CFG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // position and border logic
  logic [CB-1:0]         column;
  logic [RB-1:0]         row;
  logic [PIXEL_BITS-1:0] left_pixel;
  logic [PIXEL_BITS-1:0] upper_left_pixel;
  logic [FB-1:0]         fill;

  logic [WB-1:0] w_eff, w_m1;
  logic [HB-1:0] h_eff, h_m1;
  logic [CB-1:0] col;
  logic          last_col, last_row;
  logic          accept, accept_pix;

  always_comb begin
    if (WB'(image_width) < WB'(2))              w_eff = WB'(2);
    else if (WB'(image_width) > WB'(MAX_WIDTH)) w_eff = WB'(MAX_WIDTH);
    else                                        w_eff = WB'(image_width);
    if (HB'(image_height) < HB'(2))               h_eff = HB'(2);
    else if (HB'(image_height) > HB'(MAX_HEIGHT)) h_eff = HB'(MAX_HEIGHT);
    else                                          h_eff = HB'(image_height);
    w_m1     = w_eff - WB'(1);
    h_m1     = h_eff - HB'(1);
    col      = (WB'(column) < w_eff) ? column : w_m1[CB-1:0];
    last_col = (WB'(column) >= w_m1);
    last_row = (HB'(row) >= h_m1);
  end

  // pipeline valids and output queue occupancy
  logic          s1_valid, s2_valid;
  logic [QB:0]   q_count;
  logic [QB:0]   occupancy;

  assign occupancy  = q_count + (QB+1)'(s1_valid) + (QB+1)'(s2_valid);
  assign req.ready  = (occupancy < (QB+1)'(QD));
  assign accept     = req.valid && req.ready;
  assign accept_pix = accept && (req.req_type == REQ_PIXEL);

  always_ff @(posedge clk) begin
    if (rst) begin
      column     <= '0;
      row        <= '0;
      left_pixel <= '0;
      fill       <= '0;
    end else if (accept_pix) begin
      left_pixel <= req.pixel;
      if (FB'(col) >= fill) fill <= FB'(col) + FB'(1);
      if (last_col) begin
        column <= '0;
        row    <= last_row ? '0 : row + RB'(1);
      end else begin
        column <= col + CB'(1);
      end
    end
  end

  // upper row buffer, read before write
  logic [PIXEL_BITS-1:0] upper_row [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] up_rd;

  always_ff @(posedge clk) begin
    if (accept_pix) begin
      upper_row[col] <= req.pixel;
      up_rd          <= upper_row[col];
    end
  end

  // stage 1: prediction
  req_t                  s1_req;
  logic [PIXEL_BITS-1:0] s1_px, s1_left;
  logic [BIN_BITS-1:0]   s1_bin;
  logic                  s1_border, s1_last, s1_up_valid;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= accept;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req      <= req.req_type;
      s1_px       <= req.pixel;
      s1_bin      <= req.bin_index;
      s1_left     <= left_pixel;
      s1_border   <= (row == '0) || (col == '0);
      s1_last     <= last_col && last_row;
      s1_up_valid <= (FB'(col) < fill);
    end
  end

  logic [PIXEL_BITS-1:0] up;
  logic [9:0]            sum;
  logic [19:0]           prod;
  logic [PIXEL_BITS-1:0] pred, s1_res;
  logic [BIN_BITS-1:0]   s1_addr;

  always_comb begin
    up   = s1_up_valid ? up_rd : '0;
    sum  = 10'(s1_left) + 10'(up) + 10'(upper_left_pixel) + 10'd1;
    prod = 20'(sum) * DIV3_MUL;
    pred = prod[DIV3_SHIFT +: PIXEL_BITS];
    if (s1_border)          s1_res = '0;
    else if (pred >= s1_px) s1_res = pred - s1_px;
    else                    s1_res = s1_px - pred;
    s1_addr = (s1_req == REQ_READ) ? s1_bin : s1_res;
  end

  always_ff @(posedge clk) begin
    if (rst) upper_left_pixel <= '0;
    else if (s1_valid && s1_req == REQ_PIXEL) upper_left_pixel <= up;
  end

  // histogram memory with valid bits and forwarding of the registered last write
  logic [COUNT_BITS-1:0] histogram [BINS];
  logic [BINS-1:0]       hist_valid;
  logic [COUNT_BITS-1:0] hist_rd;

  req_t                  s2_req;
  logic [BIN_BITS-1:0]   s2_addr;
  logic                  s2_last, s2_hvalid;
  logic                  wr_valid;
  logic [BIN_BITS-1:0]   wr_addr;
  logic [COUNT_BITS-1:0] wr_data;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_new;
  logic                  s2_write;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_req    <= s1_req;
      s2_addr   <= s1_addr;
      s2_last   <= s1_last;
      s2_hvalid <= hist_valid[s1_addr];
      hist_rd   <= histogram[s1_addr];
    end
  end

  always_comb begin
    if (wr_valid && wr_addr == s2_addr) cnt_cur = wr_data;
    else if (s2_hvalid)                 cnt_cur = hist_rd;
    else                                cnt_cur = '0;
    cnt_new  = (cnt_cur == CMAX) ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    s2_write = s2_valid && (s2_req == REQ_PIXEL);
  end

  always_ff @(posedge clk) begin
    if (s2_write) histogram[s2_addr] <= cnt_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      wr_valid   <= 1'b0;
    end else begin
      wr_valid <= s2_write;
      if (s2_write) hist_valid[s2_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= s2_addr;
    wr_data <= cnt_new;
  end

  // response assembly
  logic [XB-1:0] cnt_ext;
  rsp_t          s2_rsp;

  always_comb begin
    cnt_ext = XB'(cnt_cur);
    if (s2_req == REQ_READ) begin
      s2_rsp.residual   = '0;
      s2_rsp.bin_count  = cnt_ext[BIN_COUNT_BITS-1:0];
      s2_rsp.frame_last = 1'b0;
    end else begin
      s2_rsp.residual   = s2_addr;
      s2_rsp.bin_count  = '0;
      s2_rsp.frame_last = s2_last;
    end
  end

  // output queue
  rsp_t        out_q [QD];
  logic [QB-1:0] wr_ptr, rd_ptr;
  logic          pop;

  assign pop = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s2_valid) wr_ptr <= wr_ptr + QB'(1);
      if (pop)      rd_ptr <= rd_ptr + QB'(1);
      q_count <= q_count + (QB+1)'(s2_valid) - (QB+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) out_q[wr_ptr] <= s2_rsp;
  end

  rsp_t head;

  assign head           = out_q[rd_ptr];
  assign rsp.valid      = (q_count != '0);
  assign rsp.residual   = head.residual;
  assign rsp.bin_count  = head.bin_count;
  assign rsp.frame_last = head.frame_last;

endmodule

`default_nettype wire

// File: bench/dpcm_residual_histogram_tb.sv
// ----------------------------------------------------------------------------
// dpcm_residual_histogram_tb
// Self-checking bench for the dpcm residual encoder and its histogram. A
// bit-accurate predictor tracks the row buffer, neighbors, frame position
// and saturating bin counts. Every response transaction is compared with the
// oldest prediction. Stimulus covers histogram reads after reset, a directed
// frame, size clamping, resizing in the middle of a frame, random frames at
// many sizes and back-pressure that fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcm_residual_histogram_tb;
  import dprh_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]     residual;
    logic [BIN_COUNT_BITS-1:0] bin_count;
    logic                      frame_last;
  } dprh_rsp_t;

  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic clk;
  logic rst;

  dprh_req_if req_bus ();
  dprh_rsp_if rsp_bus ();
  dprh_cfg_if cfg_bus ();

  dpcm_residual_histogram dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus),
    .cfg(cfg_bus)
  );

  // predictor state
  logic [PIXEL_BITS-1:0] row_line [MAX_WIDTH_DEF];
  logic [PIXEL_BITS-1:0] left_px;
  logic [PIXEL_BITS-1:0] upper_left_px;
  int unsigned           col_pos;
  int unsigned           row_pos;
  int unsigned           bin_hist [BINS];
  logic [SIZE_BITS-1:0]  width_reg;
  logic [SIZE_BITS-1:0]  height_reg;

  dprh_rsp_t predicted_rsp [$];

  int       fail_count;
  int       idle_cycles;
  int       burst_left;
  bit       sender_gaps;
  rx_mode_t rx_mode;
  int       rx_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_predictor();
    for (int i = 0; i < MAX_WIDTH_DEF; i++) row_line[i] = '0;
    for (int i = 0; i < BINS; i++) bin_hist[i] = 0;
    left_px       = '0;
    upper_left_px = '0;
    col_pos       = 0;
    row_pos       = 0;
    width_reg     = SIZE_RESET;
    height_reg    = SIZE_RESET;
  endfunction

  function automatic dprh_rsp_t predict_dpcm(req_t kind, logic [PIXEL_BITS-1:0] px,
                                             logic [BIN_BITS-1:0] bin);
    dprh_rsp_t   r;
    int unsigned w, h, c, up, sum, pred, res;
    bit          last_c, last_r;
    r = '0;
    if (kind == REQ_READ) begin
      r.bin_count = BIN_COUNT_BITS'(bin_hist[bin]);
      return r;
    end
    w = 32'(width_reg);
    h = 32'(height_reg);
    if (w < 2) w = 2;
    else if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h < 2) h = 2;
    else if (h > MAX_HEIGHT_DEF) h = MAX_HEIGHT_DEF;
    c      = (col_pos < w) ? col_pos : w - 1;
    last_c = (col_pos >= w - 1);
    last_r = (row_pos >= h - 1);
    up     = row_line[c];
    if (row_pos == 0 || c == 0) begin
      res = 0;
    end else begin
      sum  = left_px + up + upper_left_px + 1;
      pred = sum / 3;
      res  = (pred >= px) ? pred - px : px - pred;
    end
    if (bin_hist[res[7:0]] < COUNT_MAX) bin_hist[res[7:0]]++;
    upper_left_px = up[7:0];
    left_px       = px;
    row_line[c]   = px;
    r.residual    = res[7:0];
    r.frame_last  = last_c && last_r;
    if (last_c) begin
      col_pos = 0;
      row_pos = last_r ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom());
  endfunction

  task automatic send_item(req_t kind, logic [PIXEL_BITS-1:0] px, logic [BIN_BITS-1:0] bin);
    int gap;
    if (sender_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 25) : $urandom_range(1, 4);
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= kind;
    req_bus.pixel     <= px;
    req_bus.bin_index <= bin;
    do @(posedge clk); while (!req_bus.ready);
    predicted_rsp.push_back(predict_dpcm(kind, px, bin));
    if (burst_left > 0) burst_left--;
  endtask

  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (predicted_rsp.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_size(logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
    wait_idle();
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= CFG_IMAGE_WIDTH;
    cfg_bus.data  <= w;
    do @(posedge clk); while (!cfg_bus.ready);
    width_reg = w;
    cfg_bus.index <= CFG_IMAGE_HEIGHT;
    cfg_bus.data  <= h;
    do @(posedge clk); while (!cfg_bus.ready);
    height_reg = h;
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic finish_frame();
    while (col_pos != 0 || row_pos != 0) send_item(REQ_PIXEL, rand_byte(), rand_byte());
  endtask

  task automatic test_reset_state();
    send_item(REQ_READ, rand_byte(), 8'd0);
    send_item(REQ_READ, rand_byte(), 8'd255);
    send_item(REQ_READ, rand_byte(), 8'd170);
    send_item(REQ_READ, rand_byte(), 8'd85);
    repeat (3) send_item(REQ_PIXEL, rand_byte(), rand_byte());
    send_item(REQ_READ, rand_byte(), 8'd0);
  endtask

  task automatic test_directed_frame();
    logic [PIXEL_BITS-1:0] frame_px [12];
    frame_px = '{8'd0, 8'd0, 8'd255, 8'd255,
                 8'd0, 8'd255, 8'd255, 8'd0,
                 8'd255, 8'd170, 8'd228, 8'd0};
    set_size(9'd4, 9'd3);
    finish_frame();
    for (int i = 0; i < 12; i++) begin
      send_item(REQ_PIXEL, frame_px[i], rand_byte());
      if (i == 5) send_item(REQ_READ, rand_byte(), 8'd255);
    end
    send_item(REQ_READ, 8'd255, 8'd255);
    send_item(REQ_READ, 8'd0, 8'd0);
    send_item(REQ_READ, rand_byte(), 8'd85);
  endtask

  task automatic test_size_clamp();
    set_size(9'd0, 9'd1);
    repeat (6) send_item(REQ_PIXEL, rand_byte(), rand_byte());
    set_size(9'd1, 9'd0);
    finish_frame();
    repeat (4) send_item(REQ_PIXEL, rand_byte(), rand_byte());
    set_size(9'd511, 9'd300);
    repeat (258) send_item(REQ_PIXEL, rand_byte(), rand_byte());
    set_size(9'd3, 9'd2);
    finish_frame();
    send_item(REQ_READ, rand_byte(), 8'd0);
  endtask

  task automatic test_mid_frame_resize();
    sender_gaps = 1'b1;
    rx_mode     = RX_RANDOM;
    set_size(9'd16, 9'd8);
    finish_frame();
    repeat (21) send_item(REQ_PIXEL, rand_byte(), rand_byte());
    set_size(9'd3, 9'd8);
    repeat (8) send_item(REQ_PIXEL, rand_byte(), rand_byte());
    set_size(9'd8, 9'd3);
    repeat (12) send_item(REQ_PIXEL, rand_byte(), rand_byte());
    set_size(9'd4, 9'd4);
    repeat (6) send_item(REQ_PIXEL, rand_byte(), rand_byte());
  endtask

  task automatic test_random_frames();
    int                   pick, items, last_px, px;
    logic [SIZE_BITS-1:0] w, h;
    last_px = 128;
    for (int phase = 0; phase < 4; phase++) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) w = SIZE_BITS'($urandom_range(2, 10));
      else if (pick < 17) w = SIZE_BITS'($urandom_range(11, 40));
      else if (pick == 17) w = 9'd256;
      else w = SIZE_BITS'($urandom_range(0, 1) ? $urandom_range(0, 1) :
                                                 $urandom_range(257, 511));
      pick = $urandom_range(0, 9);
      if (pick < 8) h = SIZE_BITS'($urandom_range(2, 6));
      else if (pick == 8) h = SIZE_BITS'($urandom_range(0, 1));
      else h = SIZE_BITS'($urandom_range(257, 511));
      sender_gaps = (phase % 4 != 3);
      rx_mode     = (phase % 4 == 3) ? RX_ALWAYS : rx_mode_t'($urandom_range(0, 2));
      set_size(w, h);
      items = $urandom_range(12, 20);
      for (int i = 0; i < items; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_item(REQ_READ, rand_byte(),
                    $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : rand_byte());
        end else begin
          if ($urandom_range(0, 9) < 6) begin
            px = last_px + $urandom_range(0, 8) - 4;
            if (px < 0) px = 0;
            if (px > 255) px = 255;
          end else begin
            px = $urandom_range(0, 255);
          end
          last_px = px;
          send_item(REQ_PIXEL, px[7:0], rand_byte());
        end
      end
    end
  endtask

  task automatic test_backpressure();
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    set_size(9'd5, 9'd4);
    rx_hold_req = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      if (i % 9 == 4) send_item(REQ_READ, rand_byte(), rand_byte());
      else send_item(REQ_PIXEL, rand_byte(), rand_byte());
    end
    rx_mode = RX_PATTERN;
    repeat (15) send_item(REQ_PIXEL, rand_byte(), rand_byte());
  endtask

  // response side ready pattern and long hold-off
  initial begin
    int hold_left;
    int phase;
    hold_left = 0;
    phase     = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      phase++;
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_RANDOM:  rsp_bus.ready <= ($urandom_range(0, 9) < 7);
          RX_PATTERN: rsp_bus.ready <= ((phase % 7) < 4);
          default:    rsp_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    dprh_rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (predicted_rsp.size() == 0) begin
        $error("response transaction with no prediction pending");
        fail_count++;
      end else begin
        want = predicted_rsp.pop_front();
        if (rsp_bus.residual !== want.residual) begin
          $error("residual expected %0d actual %0d", want.residual, rsp_bus.residual);
          fail_count++;
        end
        if (rsp_bus.bin_count !== want.bin_count) begin
          $error("bin_count expected %0d actual %0d", want.bin_count, rsp_bus.bin_count);
          fail_count++;
        end
        if (rsp_bus.frame_last !== want.frame_last) begin
          $error("frame_last expected %0d actual %0d", want.frame_last, rsp_bus.frame_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    fail_count  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    sender_gaps = 1'b0;
    rx_mode     = RX_ALWAYS;
    rx_hold_req = 0;
    clear_predictor();
    rst               <= 1'b1;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= REQ_PIXEL;
    req_bus.pixel     <= '0;
    req_bus.bin_index <= '0;
    cfg_bus.valid     <= 1'b0;
    cfg_bus.index     <= CFG_IMAGE_WIDTH;
    cfg_bus.data      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_frame();
    test_size_clamp();
    test_mid_frame_resize();
    test_random_frames();
    test_backpressure();

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/dprh_pkg.sv
design/dprh_if.sv
design/dpcm_residual_histogram.sv
bench/dpcm_residual_histogram_tb.sv
